>>> rtl/core/qps_pkg.sv
// qps_pkg: shared types and constants for the quadrature position and speed unit
// used by qps_shared_unit and quadrature_position_speed_unit; no dependencies
`default_nettype none
package qps_pkg;

   // widths of the shared multiply / divide unit
   localparam int MUL_A_WIDTH  = 34;
   localparam int MUL_B_WIDTH  = 32;
   localparam int PROD_WIDTH   = MUL_A_WIDTH + MUL_B_WIDTH;
   localparam int DIVD_WIDTH   = 40;
   localparam int DIVS_WIDTH   = 16;
   localparam int STEP_WIDTH   = 6;

   // shared unit operations
   typedef enum logic {
      OP_MUL = 1'b0,
      OP_DIV = 1'b1
   } unit_op_type;

   // command word from the sequencer to the shared unit
   typedef struct packed {
      logic        start;
      unit_op_type op;
   } unit_cmd_type;

endpackage
`default_nettype wire

>>> rtl/core/qps_shared_unit.sv
// qps_shared_unit: bit-serial shift-add multiplier and restoring divider
// one step per cycle; depends on qps_pkg
`default_nettype none
module qps_shared_unit (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire qps_pkg::unit_cmd_type           cmd,
   input  wire logic [qps_pkg::MUL_A_WIDTH-1:0] mul_a,
   input  wire logic [qps_pkg::MUL_B_WIDTH-1:0] mul_b,
   input  wire logic [qps_pkg::DIVD_WIDTH-1:0]  dividend,
   input  wire logic [qps_pkg::DIVS_WIDTH-1:0]  divisor,
   output logic                                 done,
   output logic [qps_pkg::PROD_WIDTH-1:0]       product,
   output logic [qps_pkg::DIVD_WIDTH-1:0]       quotient
);
   import qps_pkg::*;

   localparam logic [STEP_WIDTH-1:0] MUL_LAST = STEP_WIDTH'(MUL_B_WIDTH - 1);
   localparam logic [STEP_WIDTH-1:0] DIV_LAST = STEP_WIDTH'(DIVD_WIDTH - 1);

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   unit_op_type             op_ff, op_in;
   logic [STEP_WIDTH-1:0]   cnt_ff, cnt_in;
   logic [MUL_A_WIDTH-1:0]  a_ff, a_in;
   logic [PROD_WIDTH-1:0]   prod_ff, prod_in;
   logic [DIVD_WIDTH-1:0]   quo_ff, quo_in;
   logic [DIVS_WIDTH-1:0]   rem_ff, rem_in;
   logic [DIVS_WIDTH-1:0]   dvs_ff, dvs_in;
   logic [MUL_A_WIDTH:0]    add_sum;
   logic [DIVS_WIDTH:0]     trial;
   logic [DIVS_WIDTH:0]     trial_diff;
   logic                    last_step;

   // one step of either operation
   always_comb begin
      add_sum    = prod_ff[0] ? ({1'b0, prod_ff[PROD_WIDTH-1:MUL_B_WIDTH]} + {1'b0, a_ff})
                              : {1'b0, prod_ff[PROD_WIDTH-1:MUL_B_WIDTH]};
      trial      = {rem_ff, quo_ff[DIVD_WIDTH-1]};
      trial_diff = trial - {1'b0, dvs_ff};
      last_step  = (op_ff == OP_MUL) ? (cnt_ff == MUL_LAST) : (cnt_ff == DIV_LAST);

      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      prod_in = prod_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;

      if (busy_ff) begin
         cnt_in = cnt_ff + 1'b1;
         if (op_ff == OP_MUL) begin
            prod_in = {add_sum, prod_ff[MUL_B_WIDTH-1:1]};
         end else if (trial >= {1'b0, dvs_ff}) begin
            rem_in = trial_diff[DIVS_WIDTH-1:0];
            quo_in = {quo_ff[DIVD_WIDTH-2:0], 1'b1};
         end else begin
            rem_in = trial[DIVS_WIDTH-1:0];
            quo_in = {quo_ff[DIVD_WIDTH-2:0], 1'b0};
         end
         if (last_step) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (cmd.start) begin
         busy_in = 1'b1;
         op_in   = cmd.op;
         cnt_in  = '0;
         a_in    = mul_a;
         prod_in = {{MUL_A_WIDTH{1'b0}}, mul_b};
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      cnt_ff  <= cnt_in;
      a_ff    <= a_in;
      prod_ff <= prod_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
   end

   assign done     = done_ff;
   assign product  = prod_ff;
   assign quotient = quo_ff;

   // done is raised only at the end of a running operation
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("done without a running operation");

   // a running divide keeps its remainder below the divisor
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && op_ff == OP_DIV && cnt_ff != '0) |-> (rem_ff < dvs_ff))
      else $error("divider remainder out of range");

   // start is not issued while the unit is busy
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !cmd.start)
      else $error("start while busy");

endmodule
`default_nettype wire

>>> rtl/core/quadrature_position_speed_unit.sv
// quadrature_position_speed_unit: angle, frequency and speed from counter snapshots
// sequencer around one shared multiply / divide unit; depends on qps_pkg, qps_shared_unit
// steps: mechanical angle, electrical angle and frequency multiplies; on a timeout, fast speed
// multiplies; on a position event, a divide (skipped when the period is zero) and a multiply; then the result loads
// one word at a time, next word accepted in the cycle after the result register loads
// reset: synchronous, returns control and configuration registers to defaults and clears all held state
`default_nettype none
module quadrature_position_speed_unit #(
   parameter int COUNT_WIDTH     = 16,
   parameter int ANGLE_FRAC_BITS = 27
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [COUNT_WIDTH-1:0] req_position_count,
   input  wire logic                   req_count_up,
   input  wire logic                   req_unit_timeout,
   input  wire logic [COUNT_WIDTH-1:0] req_latched_count,
   input  wire logic                   req_position_event,
   input  wire logic [15:0]            req_capture_period,
   input  wire logic                   req_capture_overflow,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic                        rsp_direction_out,
   output logic signed [31:0]          rsp_mech_angle,
   output logic signed [31:0]          rsp_elec_angle,
   output logic signed [31:0]          rsp_elec_freq,
   output logic signed [31:0]          rsp_speed_fast,
   output logic signed [16:0]          rsp_rpm_fast,
   output logic [30:0]                 rsp_speed_slow,
   output logic signed [16:0]          rsp_rpm_slow,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [2:0]             csr_index,
   input  wire logic [39:0]            csr_data
);
   import qps_pkg::*;

   localparam int SS = 32 - ANGLE_FRAC_BITS;
   localparam int FS = ANGLE_FRAC_BITS - 16;
   localparam int RW = COUNT_WIDTH + 2;
   localparam longint TWO_PI_L = (64'd26986075409 + (64'd1 << (SS - 1))) >> SS;
   localparam logic signed [67:0] TWO_PI_Q = 68'(TWO_PI_L);
   localparam logic signed [67:0] SAT_HI   = 68'sd2147483647;
   localparam logic signed [67:0] SAT_LO   = -68'sd2147483648;
   localparam logic signed [65:0] ONE_T    = 66'sd1073741824;
   localparam logic [31:0]        ONE_Q30  = 32'd1073741824;
   localparam logic [31:0]        FREQ_GAIN = 32'd5230;

   // register indexes
   localparam logic [2:0] CSR_ANGLE_OFFSET = 3'd0;
   localparam logic [2:0] CSR_MECH_SCALE   = 3'd1;
   localparam logic [2:0] CSR_POLE_PAIRS   = 3'd2;
   localparam logic [2:0] CSR_SPEED_SCALE  = 3'd3;
   localparam logic [2:0] CSR_BASE_RPM     = 3'd4;

   typedef enum logic [9:0] {
      S_IDLE = 10'b0000000001,
      S_MECH = 10'b0000000010,
      S_ELEC = 10'b0000000100,
      S_FREQ = 10'b0000001000,
      S_NEWP = 10'b0000010000,
      S_OLDP = 10'b0000100000,
      S_RPMF = 10'b0001000000,
      S_DIV  = 10'b0010000000,
      S_RPMS = 10'b0100000000,
      S_OUT  = 10'b1000000000
   } state_type;

   // one wrap by 2*pi, then saturate to 32 bits
   function automatic logic signed [31:0] wrap_sat(input logic signed [67:0] x);
      logic signed [67:0] y;
      y = x;
      if (x > TWO_PI_Q) y = x - TWO_PI_Q;
      else if (x < -TWO_PI_Q) y = x + TWO_PI_Q;
      if (y > SAT_HI) return 32'sh7FFFFFFF;
      if (y < SAT_LO) return 32'sh80000000;
      return y[31:0];
   endfunction

   // saturate only
   function automatic logic signed [31:0] sat32(input logic signed [67:0] x);
      if (x > SAT_HI) return 32'sh7FFFFFFF;
      if (x < SAT_LO) return 32'sh80000000;
      return x[31:0];
   endfunction

   // apply a sign to a magnitude
   function automatic logic signed [67:0] signed_of(input logic neg, input logic [65:0] m);
      logic signed [67:0] v;
      v = $signed({2'b00, m});
      return neg ? -v : v;
   endfunction

   // configuration registers
   logic signed [15:0] angle_offset_ff;
   logic [31:0]        mech_scale_ff;
   logic [4:0]         pole_pairs_ff;
   logic [39:0]        speed_scale_ff;
   logic [15:0]        base_rpm_ff;

   // sequencer and captured word
   state_type              state_ff, state_in;
   logic                   issued_ff, issued_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   up_ff, up_in;
   logic                   tmo_ff, tmo_in;
   logic [COUNT_WIDTH-1:0] latched_ff, latched_in;
   logic                   evt_ff, evt_in;
   logic [15:0]            per_ff, per_in;

   // working and held values
   logic signed [31:0]     mech_ff, mech_in;
   logic signed [31:0]     elec_ff, elec_in;
   logic signed [31:0]     freq_ff, freq_in;
   logic signed [31:0]     prev_elec_ff, prev_elec_in;
   logic [COUNT_WIDTH-1:0] prev_latched_ff, prev_latched_in;
   logic [63:0]            newp_ff, newp_in;
   logic signed [31:0]     held_speed_fast_ff, held_speed_fast_in;
   logic signed [16:0]     held_rpm_fast_ff, held_rpm_fast_in;
   logic [30:0]            held_speed_slow_ff, held_speed_slow_in;
   logic signed [16:0]     held_rpm_slow_ff, held_rpm_slow_in;

   // result word
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   o_dir_ff, o_dir_in;
   logic signed [31:0]     o_mech_ff, o_mech_in;
   logic signed [31:0]     o_elec_ff, o_elec_in;
   logic signed [31:0]     o_freq_ff, o_freq_in;
   logic signed [31:0]     o_sf_ff, o_sf_in;
   logic signed [16:0]     o_rf_ff, o_rf_in;
   logic [30:0]            o_ss_ff, o_ss_in;
   logic signed [16:0]     o_rs_ff, o_rs_in;

   // shared unit connections
   unit_cmd_type           cmd;
   logic [MUL_A_WIDTH-1:0] mul_a;
   logic [MUL_B_WIDTH-1:0] mul_b;
   logic                   unit_done;
   logic [PROD_WIDTH-1:0]  product;
   logic [DIVD_WIDTH-1:0]  quotient;

   // operand preparation
   logic signed [RW-1:0]   raw;
   logic [RW-1:0]          raw_mag;
   logic [31:0]            mech_mag;
   logic signed [32:0]     diff;
   logic [32:0]            diff_mag;
   logic [31:0]            sf_mag;
   logic [15:0]            per_eff;
   logic signed [65:0]     t_val;
   logic [65:0]            p_shift;

   always_comb begin
      raw      = $signed({2'b00, count_ff}) + RW'(angle_offset_ff);
      raw_mag  = raw[RW-1] ? RW'(-raw) : raw;
      mech_mag = mech_ff[31] ? 32'(-mech_ff) : mech_ff;
      diff     = 33'(elec_ff) - 33'(prev_elec_ff);
      diff_mag = diff[32] ? 33'(-diff) : diff;
      sf_mag   = held_speed_fast_ff[31] ? 32'(-held_speed_fast_ff) : held_speed_fast_ff;
      per_eff  = per_ff;
   end

   qps_shared_unit u_unit (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .mul_a    (mul_a),
      .mul_b    (mul_b),
      .dividend (speed_scale_ff),
      .divisor  (per_eff),
      .done     (unit_done),
      .product  (product),
      .quotient (quotient)
   );

   // sequencer
   always_comb begin
      state_in           = state_ff;
      issued_in          = issued_ff;
      count_in           = count_ff;
      up_in              = up_ff;
      tmo_in             = tmo_ff;
      latched_in         = latched_ff;
      evt_in             = evt_ff;
      per_in             = per_ff;
      mech_in            = mech_ff;
      elec_in            = elec_ff;
      freq_in            = freq_ff;
      prev_elec_in       = prev_elec_ff;
      prev_latched_in    = prev_latched_ff;
      newp_in            = newp_ff;
      held_speed_fast_in = held_speed_fast_ff;
      held_rpm_fast_in   = held_rpm_fast_ff;
      held_speed_slow_in = held_speed_slow_ff;
      held_rpm_slow_in   = held_rpm_slow_ff;
      rsp_valid_in       = rsp_valid_ff && rsp_stall;
      o_dir_in           = o_dir_ff;
      o_mech_in          = o_mech_ff;
      o_elec_in          = o_elec_ff;
      o_freq_in          = o_freq_ff;
      o_sf_in            = o_sf_ff;
      o_rf_in            = o_rf_ff;
      o_ss_in            = o_ss_ff;
      o_rs_in            = o_rs_ff;
      cmd.start          = 1'b0;
      cmd.op             = OP_MUL;
      mul_a              = '0;
      mul_b              = '0;
      p_shift            = '0;
      t_val              = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               count_in   = req_position_count;
               up_in      = req_count_up;
               tmo_in     = req_unit_timeout;
               latched_in = req_latched_count;
               evt_in     = req_position_event;
               per_in     = req_capture_overflow ? 16'hFFFF : req_capture_period;
               state_in   = S_MECH;
            end
         end
         S_MECH: begin
            mul_a     = MUL_A_WIDTH'(raw_mag);
            mul_b     = mech_scale_ff;
            cmd.start = !issued_ff;
            p_shift   = 66'(product >> SS);
            if (unit_done) begin
               mech_in  = wrap_sat(signed_of(raw[RW-1], p_shift));
               state_in = S_ELEC;
            end
         end
         S_ELEC: begin
            mul_a     = MUL_A_WIDTH'(mech_mag);
            mul_b     = 32'(pole_pairs_ff);
            cmd.start = !issued_ff;
            if (unit_done) begin
               elec_in  = wrap_sat(signed_of(mech_ff[31], product));
               state_in = S_FREQ;
            end
         end
         S_FREQ: begin
            mul_a     = MUL_A_WIDTH'(diff_mag);
            mul_b     = FREQ_GAIN;
            cmd.start = !issued_ff;
            p_shift   = 66'(product >> FS);
            if (unit_done) begin
               freq_in      = sat32(signed_of(diff[32], p_shift));
               prev_elec_in = elec_ff;
               if (tmo_ff) state_in = S_NEWP;
               else if (evt_ff) state_in = S_DIV;
               else state_in = S_OUT;
            end
         end
         S_NEWP: begin
            mul_a     = MUL_A_WIDTH'(latched_ff);
            mul_b     = mech_scale_ff;
            cmd.start = !issued_ff;
            if (unit_done) begin
               newp_in  = 64'(product >> 2);
               state_in = S_OLDP;
            end
         end
         S_OLDP: begin
            mul_a     = MUL_A_WIDTH'(prev_latched_ff);
            mul_b     = mech_scale_ff;
            cmd.start = !issued_ff;
            p_shift   = 66'(product >> 2);
            t_val     = $signed({2'b00, newp_ff}) - $signed(p_shift);
            if (!up_ff && t_val > 66'sd0) t_val = t_val - ONE_T;
            else if (up_ff && t_val < 66'sd0) t_val = t_val + ONE_T;
            if (t_val > ONE_T) t_val = ONE_T;
            else if (t_val < -ONE_T) t_val = -ONE_T;
            if (unit_done) begin
               held_speed_fast_in = t_val[31:0];
               prev_latched_in    = latched_ff;
               state_in           = S_RPMF;
            end
         end
         S_RPMF: begin
            mul_a     = MUL_A_WIDTH'(sf_mag);
            mul_b     = 32'(base_rpm_ff);
            cmd.start = !issued_ff;
            p_shift   = 66'(product >> 30);
            if (unit_done) begin
               held_rpm_fast_in = held_speed_fast_ff[31] ? -$signed({1'b0, p_shift[15:0]})
                                                         : $signed({1'b0, p_shift[15:0]});
               state_in = evt_ff ? S_DIV : S_OUT;
            end
         end
         S_DIV: begin
            cmd.op = OP_DIV;
            if (per_ff == '0) begin
               held_speed_slow_in = 31'(ONE_Q30);
               state_in           = S_RPMS;
            end else begin
               cmd.start = !issued_ff;
               if (unit_done) begin
                  held_speed_slow_in = (quotient > 40'(ONE_Q30)) ? 31'(ONE_Q30)
                                                                 : quotient[30:0];
                  state_in = S_RPMS;
               end
            end
         end
         S_RPMS: begin
            mul_a     = MUL_A_WIDTH'(held_speed_slow_ff);
            mul_b     = 32'(base_rpm_ff);
            cmd.start = !issued_ff;
            p_shift   = 66'(product >> 30);
            if (unit_done) begin
               held_rpm_slow_in = up_ff ? $signed({1'b0, p_shift[15:0]})
                                        : -$signed({1'b0, p_shift[15:0]});
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               o_dir_in     = up_ff;
               o_mech_in    = mech_ff;
               o_elec_in    = elec_ff;
               o_freq_in    = freq_ff;
               o_sf_in      = held_speed_fast_ff;
               o_rf_in      = held_rpm_fast_ff;
               o_ss_in      = held_speed_slow_ff;
               o_rs_in      = held_rpm_slow_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // track the outstanding unit operation
      if (cmd.start) issued_in = 1'b1;
      if (unit_done) issued_in = 1'b0;
   end

   // control and held state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= S_IDLE;
         issued_ff          <= 1'b0;
         rsp_valid_ff       <= 1'b0;
         prev_elec_ff       <= '0;
         prev_latched_ff    <= '0;
         held_speed_fast_ff <= '0;
         held_rpm_fast_ff   <= '0;
         held_speed_slow_ff <= '0;
         held_rpm_slow_ff   <= '0;
      end else begin
         state_ff           <= state_in;
         issued_ff          <= issued_in;
         rsp_valid_ff       <= rsp_valid_in;
         prev_elec_ff       <= prev_elec_in;
         prev_latched_ff    <= prev_latched_in;
         held_speed_fast_ff <= held_speed_fast_in;
         held_rpm_fast_ff   <= held_rpm_fast_in;
         held_speed_slow_ff <= held_speed_slow_in;
         held_rpm_slow_ff   <= held_rpm_slow_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      count_ff   <= count_in;
      up_ff      <= up_in;
      tmo_ff     <= tmo_in;
      latched_ff <= latched_in;
      evt_ff     <= evt_in;
      per_ff     <= per_in;
      mech_ff    <= mech_in;
      elec_ff    <= elec_in;
      freq_ff    <= freq_in;
      newp_ff    <= newp_in;
      o_dir_ff   <= o_dir_in;
      o_mech_ff  <= o_mech_in;
      o_elec_ff  <= o_elec_in;
      o_freq_ff  <= o_freq_in;
      o_sf_ff    <= o_sf_in;
      o_rf_ff    <= o_rf_in;
      o_ss_ff    <= o_ss_in;
      o_rs_ff    <= o_rs_in;
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         angle_offset_ff <= '0;
         mech_scale_ff   <= 32'd6746518;
         pole_pairs_ff   <= 5'd2;
         speed_scale_ff  <= '0;
         base_rpm_ff     <= 16'd1800;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_ANGLE_OFFSET: angle_offset_ff <= $signed(csr_data[15:0]);
            CSR_MECH_SCALE:   mech_scale_ff   <= csr_data[31:0];
            CSR_POLE_PAIRS:   pole_pairs_ff   <= csr_data[4:0];
            CSR_SPEED_SCALE:  speed_scale_ff  <= csr_data;
            CSR_BASE_RPM:     base_rpm_ff     <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   assign csr_ready         = 1'b1;
   assign req_stall         = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_direction_out = o_dir_ff;
   assign rsp_mech_angle    = o_mech_ff;
   assign rsp_elec_angle    = o_elec_ff;
   assign rsp_elec_freq     = o_freq_ff;
   assign rsp_speed_fast    = o_sf_ff;
   assign rsp_rpm_fast      = o_rf_ff;
   assign rsp_speed_slow    = o_ss_ff;
   assign rsp_rpm_slow      = o_rs_ff;

   // an accepted word starts the angle computation
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == S_MECH))
      else $error("accepted word did not start");

   // slow speed never exceeds one per unit
   a_slow_capped: assert property (@(posedge clock) disable iff (reset)
      held_speed_slow_ff <= 31'(ONE_Q30))
      else $error("slow speed above one");

   // fast speed stays within plus or minus one per unit
   a_fast_clamped: assert property (@(posedge clock) disable iff (reset)
      (held_speed_fast_ff <= $signed(ONE_Q30)) && (held_speed_fast_ff >= -$signed(ONE_Q30)))
      else $error("fast speed out of range");

   // unit results arrive only for an issued operation
   a_done_issued: assert property (@(posedge clock) disable iff (reset)
      unit_done |-> issued_ff)
      else $error("unit result without request");

endmodule
`default_nettype wire

>>> tb/quadrature_position_speed_unit_test.sv
// quadrature_position_speed_unit_test: self-checking bench for the quadrature position unit
// predicts angle, frequency and held speeds per word; depends on the unit rtl
`timescale 1ns / 1ps
module quadrature_position_speed_unit_test;

   // register indexes
   localparam logic [2:0] REG_ANGLE_OFFSET = 3'd0;
   localparam logic [2:0] REG_MECH_SCALE   = 3'd1;
   localparam logic [2:0] REG_POLE_PAIRS   = 3'd2;
   localparam logic [2:0] REG_SPEED_SCALE  = 3'd3;
   localparam logic [2:0] REG_BASE_RPM     = 3'd4;
   localparam logic [2:0] REG_UNUSED       = 3'd7;

   localparam longint TWO_PI_ANGLE = (64'd26986075409 + 64'd16) >> 5;
   localparam longint ONE_PU       = 64'sd1 << 30;
   localparam int      FREQ_GAIN    = 5230;

   typedef struct packed {
      logic [15:0] position_count;
      logic        count_up;
      logic        unit_timeout;
      logic [15:0] latched_count;
      logic        position_event;
      logic [15:0] capture_period;
      logic        capture_overflow;
   } sample_type;

   typedef struct packed {
      logic        direction_out;
      logic [31:0] mech_angle;
      logic [31:0] elec_angle;
      logic [31:0] elec_freq;
      logic [31:0] speed_fast;
      logic [16:0] rpm_fast;
      logic [30:0] speed_slow;
      logic [16:0] rpm_slow;
   } estimate_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   sample_type drv = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_direction_out;
   logic signed [31:0] rsp_mech_angle, rsp_elec_angle, rsp_elec_freq, rsp_speed_fast;
   logic signed [16:0] rsp_rpm_fast, rsp_rpm_slow;
   logic [30:0] rsp_speed_slow;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [2:0] csr_index = '0;
   logic [39:0] csr_data = '0;

   // predictor copies of registers and state
   longint cfg_offset;
   longint unsigned cfg_mech_scale, cfg_pole_pairs, cfg_speed_scale, cfg_base_rpm;
   longint unsigned last_latched;
   longint last_elec, hold_speed_fast, hold_rpm_fast, hold_speed_slow, hold_rpm_slow;

   estimate_type expected_estimates[$];
   int  errors = 0;
   bit  rsp_idle_on = 1'b1;
   bit  req_idle_on = 1'b1;
   bit  long_hold = 1'b0;

   quadrature_position_speed_unit uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_position_count(drv.position_count), .req_count_up(drv.count_up),
      .req_unit_timeout(drv.unit_timeout), .req_latched_count(drv.latched_count),
      .req_position_event(drv.position_event), .req_capture_period(drv.capture_period),
      .req_capture_overflow(drv.capture_overflow),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_direction_out(rsp_direction_out), .rsp_mech_angle(rsp_mech_angle),
      .rsp_elec_angle(rsp_elec_angle), .rsp_elec_freq(rsp_elec_freq),
      .rsp_speed_fast(rsp_speed_fast), .rsp_rpm_fast(rsp_rpm_fast),
      .rsp_speed_slow(rsp_speed_slow), .rsp_rpm_slow(rsp_rpm_slow),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // truncating signed shift
   function automatic longint trunc_shift(longint v, int s);
      longint m;
      m = (v < 0) ? -v : v;
      m = m >>> s;
      return (v < 0) ? -m : m;
   endfunction

   function automatic longint sat_word(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint wrap_angle(longint x);
      if (x > TWO_PI_ANGLE) x = x - TWO_PI_ANGLE;
      else if (x < -TWO_PI_ANGLE) x = x + TWO_PI_ANGLE;
      return sat_word(x);
   endfunction

   // position times scale, floored, for nonnegative counts (no 64-bit overflow)
   function automatic longint unsigned scaled_pos(longint unsigned m, int s);
      longint unsigned a, b;
      a = m * (cfg_mech_scale >> 16);
      b = m * (cfg_mech_scale & 64'hFFFF);
      return (a << (16 - s)) + (b >> s);
   endfunction

   function automatic longint to_rpm(longint spd);
      return trunc_shift(longint'(cfg_base_rpm) * spd, 30);
   endfunction

   // compute the estimate for one accepted sample and advance the state
   function automatic estimate_type estimate_sample(sample_type smp);
      estimate_type r;
      longint raw, mag, mech, elec, fr, np, op, t;
      longint unsigned p, s;
      raw  = longint'(smp.position_count) + cfg_offset;
      mag  = longint'(scaled_pos((raw < 0) ? -raw : raw, 5));
      mech = wrap_angle((raw < 0) ? -mag : mag);
      elec = wrap_angle(mech * longint'(cfg_pole_pairs));
      fr   = sat_word(trunc_shift((elec - last_elec) * FREQ_GAIN, 11));
      last_elec = elec;
      if (smp.unit_timeout) begin
         np = longint'(scaled_pos(smp.latched_count, 2));
         op = longint'(scaled_pos(last_latched, 2));
         t = np - op;
         if (!smp.count_up && np > op) t = t - ONE_PU;
         else if (smp.count_up && np < op) t = t + ONE_PU;
         if (t > ONE_PU) t = ONE_PU;
         else if (t < -ONE_PU) t = -ONE_PU;
         hold_speed_fast = t;
         hold_rpm_fast = to_rpm(t);
         last_latched = smp.latched_count;
      end
      if (smp.position_event) begin
         p = smp.capture_overflow ? 64'hFFFF : longint'(smp.capture_period);
         if (p == 0) s = ONE_PU;
         else begin
            s = cfg_speed_scale / p;
            if (s > ONE_PU) s = ONE_PU;
         end
         hold_speed_slow = longint'(s);
         hold_rpm_slow = smp.count_up ? to_rpm(longint'(s)) : -to_rpm(longint'(s));
      end
      r.direction_out = smp.count_up;
      r.mech_angle = mech[31:0];
      r.elec_angle = elec[31:0];
      r.elec_freq  = fr[31:0];
      r.speed_fast = hold_speed_fast[31:0];
      r.rpm_fast   = hold_rpm_fast[16:0];
      r.speed_slow = hold_speed_slow[30:0];
      r.rpm_slow   = hold_rpm_slow[16:0];
      return r;
   endfunction

   // send one word, with random gaps before it; valid stays up until the next word or drain
   task automatic send_sample(sample_type smp);
      int gap;
      if (req_idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 11);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      drv <= smp;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_estimates.push_back(estimate_sample(smp));
      @(negedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [39:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         REG_ANGLE_OFFSET: cfg_offset = longint'($signed(val[15:0]));
         REG_MECH_SCALE:   cfg_mech_scale = val[31:0];
         REG_POLE_PAIRS:   cfg_pole_pairs = val[4:0];
         REG_SPEED_SCALE:  cfg_speed_scale = val;
         REG_BASE_RPM:     cfg_base_rpm = val[15:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // stop offering and wait until the unit has drained
   task automatic drain();
      req_valid <= 1'b0;
      while (expected_estimates.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   function automatic sample_type random_sample();
      sample_type s;
      s = sample_type'({$urandom, $urandom});
      s.unit_timeout = ($urandom_range(0, 2) == 0);
      s.position_event = ($urandom_range(0, 2) == 0);
      s.capture_overflow = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 9) == 0) s.capture_period = 16'd0;
      else if ($urandom_range(0, 2) == 0) s.capture_period = 16'($urandom_range(1, 40));
      return s;
   endfunction

   // extremes of counts, all flags, zero period, overflow
   task automatic test_directed();
      sample_type s;
      s = '0;
      send_sample(s);
      s = '1;
      send_sample(s);
      s = '0; s.position_count = 16'hFFFF; s.count_up = 1'b1; s.unit_timeout = 1'b1;
      s.latched_count = 16'h0001;
      send_sample(s);
      s.latched_count = 16'hFFFF; s.count_up = 1'b0;
      send_sample(s);
      s.latched_count = 16'h0000; s.count_up = 1'b1;
      send_sample(s);
      s.latched_count = 16'h8000; s.count_up = 1'b0;
      send_sample(s);
      s = '0; s.position_event = 1'b1; s.capture_period = 16'd0;
      send_sample(s);
      s.count_up = 1'b1; s.capture_period = 16'd1;
      send_sample(s);
      s.capture_overflow = 1'b1;
      send_sample(s);
      s.capture_overflow = 1'b0; s.capture_period = 16'hFFFF; s.position_count = 16'h7FFF;
      send_sample(s);
      s.count_up = 1'b0; s.capture_period = 16'd3;
      send_sample(s);
   endtask

   task automatic test_register_settings();
      write_reg(REG_SPEED_SCALE, 40'hFF_FFFF_FFFF);
      write_reg(REG_UNUSED, 40'h12_3456_789A);
      test_directed();
      drain();
      write_reg(REG_ANGLE_OFFSET, 40'h8000);
      write_reg(REG_MECH_SCALE, 40'hFFFF_FFFF);
      write_reg(REG_POLE_PAIRS, 40'd16);
      write_reg(REG_BASE_RPM, 40'hFFFF);
      test_directed();
      drain();
      write_reg(REG_ANGLE_OFFSET, 40'h7FFF);
      write_reg(REG_MECH_SCALE, 40'd0);
      write_reg(REG_POLE_PAIRS, 40'd1);
      write_reg(REG_SPEED_SCALE, 40'd0);
      write_reg(REG_BASE_RPM, 40'd0);
      test_directed();
      drain();
      write_reg(REG_POLE_PAIRS, 40'd0);
      test_directed();
      drain();
   endtask

   // random samples over several random settings
   task automatic test_random(int count);
      for (int i = 0; i < count; i++) begin
         if (i % 200 == 0) begin
            drain();
            write_reg(REG_ANGLE_OFFSET, $urandom);
            write_reg(REG_MECH_SCALE, $urandom_range(0, 3) == 0 ? $urandom : 32'd6746518);
            write_reg(REG_POLE_PAIRS, $urandom_range(1, 16));
            write_reg(REG_SPEED_SCALE, {$urandom, $urandom} >> $urandom_range(0, 30));
            write_reg(REG_BASE_RPM, $urandom);
         end
         send_sample(random_sample());
      end
   endtask

   // receiver holds off while the sender keeps offering
   task automatic test_backpressure();
      long_hold = 1'b1;
      repeat (8) send_sample(random_sample());
      long_hold = 1'b0;
   endtask

   // receiver stall generator
   initial begin
      @(negedge clock);
      forever begin
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (2000) @(negedge clock);
            rsp_stall <= 1'b0;
            while (long_hold) @(negedge clock);
         end else if (rsp_idle_on && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 11)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
         @(negedge clock);
      end
   end

   // result checker
   always @(posedge clock) begin
      estimate_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_direction_out, rsp_mech_angle, rsp_elec_angle, rsp_elec_freq,
                rsp_speed_fast, rsp_rpm_fast, rsp_speed_slow, rsp_rpm_slow};
         if (expected_estimates.size() == 0) begin
            $display("%0t: unexpected word %h", $time, got);
            errors++;
         end else begin
            want = expected_estimates.pop_front();
            if (got.direction_out !== want.direction_out) begin
               $display("%0t: direction_out exp %h got %h", $time, want.direction_out,
                        got.direction_out);
               errors++;
            end
            if (got.mech_angle !== want.mech_angle) begin
               $display("%0t: mech_angle exp %h got %h", $time, want.mech_angle,
                        got.mech_angle);
               errors++;
            end
            if (got.elec_angle !== want.elec_angle) begin
               $display("%0t: elec_angle exp %h got %h", $time, want.elec_angle,
                        got.elec_angle);
               errors++;
            end
            if (got.elec_freq !== want.elec_freq) begin
               $display("%0t: elec_freq exp %h got %h", $time, want.elec_freq,
                        got.elec_freq);
               errors++;
            end
            if (got.speed_fast !== want.speed_fast) begin
               $display("%0t: speed_fast exp %h got %h", $time, want.speed_fast,
                        got.speed_fast);
               errors++;
            end
            if (got.rpm_fast !== want.rpm_fast) begin
               $display("%0t: rpm_fast exp %h got %h", $time, want.rpm_fast, got.rpm_fast);
               errors++;
            end
            if (got.speed_slow !== want.speed_slow) begin
               $display("%0t: speed_slow exp %h got %h", $time, want.speed_slow,
                        got.speed_slow);
               errors++;
            end
            if (got.rpm_slow !== want.rpm_slow) begin
               $display("%0t: rpm_slow exp %h got %h", $time, want.rpm_slow, got.rpm_slow);
               errors++;
            end
         end
      end
   end

   // run limit
   initial begin
      #20ms;
      $display("** quadrature_position_speed_unit: FAILED **");
      $finish;
   end

   initial begin
      cfg_offset = 0; cfg_mech_scale = 6746518; cfg_pole_pairs = 2;
      cfg_speed_scale = 0; cfg_base_rpm = 1800;
      last_latched = 0; last_elec = 0;
      hold_speed_fast = 0; hold_rpm_fast = 0; hold_speed_slow = 0; hold_rpm_slow = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      drain();
      test_register_settings();
      test_backpressure();
      test_random(1100);
      drain();
      rsp_idle_on = 1'b0;
      req_idle_on = 1'b0;
      test_random(100);
      drain();
      repeat (300) @(negedge clock);
      if (errors == 0 && expected_estimates.size() == 0)
         $display("** quadrature_position_speed_unit: PASSED **");
      else
         $display("** quadrature_position_speed_unit: FAILED **");
      $finish;
   end

endmodule
